/* sv/fpa_pkg.sv */
// Shared types, codes and field widths for the fixed-partition allocator.
package fpa_pkg;

    localparam int ID_W       = 14;
    localparam int SIZE_W     = 20;
    localparam int STATUS_W   = 3;
    localparam int SEC_IDX_W  = 4;
    localparam int COUNT_W    = 5;
    localparam int NSEC_W     = 5;
    localparam int BYTES_W    = 17;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 1;

    localparam logic [NSEC_W-1:0]  NSEC_RESET  = 5'd16;
    localparam logic [BYTES_W-1:0] BYTES_RESET = 17'd4096;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_UNLOAD = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_SECTIONS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTION_BYTES = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_LOADED     = 3'd0,
        ST_QUEUED     = 3'd1,
        ST_TOO_LARGE  = 3'd2,
        ST_QUEUE_FULL = 3'd3,
        ST_UNLOADED   = 3'd4,
        ST_NOT_FOUND  = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_PLACE,
        S_EMIT
    } ctl_state_t;

    typedef enum logic [1:0] {
        WR_LOAD,
        WR_CLEAR,
        WR_PLACE_MATCH,
        WR_PLACE_FREE
    } wr_sel_t;

    typedef struct packed {
        logic    take;
        logic    scan_start;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    push;
        logic    pop;
        logic    res_en;
        status_t res_code;
        logic    emit;
    } ctl_cmd_t;

    typedef struct packed {
        logic op;
        logic too_large;
        logic id_zero;
        logic scan_done;
        logic scan_hit;
        logic free_below;
        logic queue_full;
        logic queue_empty;
        logic out_busy;
    } dp_stat_t;

endpackage

/* sv/fixed_partition_allocator_unit.sv */
// Top level of the fixed-partition allocator: sequencer, datapath and checks.
//
// One request is handled at a time. A load that is too large, or an unload
// of id 0, goes from S_DECIDE straight to S_EMIT without a table walk.
// Any other request walks the section table one entry per cycle through the
// single read port of the owner memory, and the walk stops at the first
// match or at the last section in use. The request also passes through
// S_PLACE when a waiting process goes into a lower free section.
// The result sits in an output register, so the next item is taken while an
// earlier result still waits for out_ready.
module fixed_partition_allocator_unit #(
    parameter int NUM_SECTIONS = 16,
    parameter int QUEUE_DEPTH  = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [fpa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fpa_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            operation,
    input  logic [fpa_pkg::ID_W-1:0]        proc_id,
    input  logic [fpa_pkg::SIZE_W-1:0]      proc_size,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [fpa_pkg::STATUS_W-1:0]    status,
    output logic [fpa_pkg::SEC_IDX_W-1:0]   section_index,
    output logic [fpa_pkg::ID_W-1:0]        placed_id,
    output logic [fpa_pkg::COUNT_W-1:0]     queue_count
);
    import fpa_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;

    fpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fpa_datapath #(
        .NUM_SECTIONS (NUM_SECTIONS),
        .QUEUE_DEPTH  (QUEUE_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .operation     (operation),
        .proc_id       (proc_id),
        .proc_size     (proc_size),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .section_index (section_index),
        .placed_id     (placed_id),
        .queue_count   (queue_count)
    );

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> !stat.queue_full)
        else $error("push into a full wait queue");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> !stat.queue_empty)
        else $error("pop from an empty wait queue");

    a_accept_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !cmd.emit)
        else $error("result emitted right after item accept");

    a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid || out_ready))
        else $error("result overwrites a pending output item");

endmodule

/* sv/fpa_ctrl.sv */
// Request sequencer: steps each item through check, table walk, update and result.
module fpa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  fpa_pkg::dp_stat_t  stat,
    output fpa_pkg::ctl_cmd_t  cmd
);
    import fpa_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if ((stat.op == OP_LOAD && stat.too_large) ||
                    (stat.op == OP_UNLOAD && stat.id_zero))
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    if (stat.op == OP_UNLOAD && stat.scan_hit && !stat.queue_empty &&
                        stat.free_below)
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_PLACE:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!stat.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.wr_sel     = WR_LOAD;
        cmd.res_code   = ST_NOT_FOUND;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
            end
            S_DECIDE:
            begin
                if (stat.op == OP_LOAD && stat.too_large)
                begin
                    cmd.res_en   = 1'b1;
                    cmd.res_code = ST_TOO_LARGE;
                end
                else if (stat.op == OP_UNLOAD && stat.id_zero)
                begin
                    cmd.res_en   = 1'b1;
                    cmd.res_code = ST_NOT_FOUND;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    cmd.res_en = 1'b1;
                    if (stat.op == OP_LOAD)
                    begin
                        if (stat.scan_hit)
                        begin
                            cmd.wr_en    = 1'b1;
                            cmd.wr_sel   = WR_LOAD;
                            cmd.res_code = ST_LOADED;
                        end
                        else if (stat.queue_full)
                        begin
                            cmd.res_code = ST_QUEUE_FULL;
                        end
                        else
                        begin
                            cmd.push     = 1'b1;
                            cmd.res_code = ST_QUEUED;
                        end
                    end
                    else if (!stat.scan_hit)
                    begin
                        cmd.res_code = ST_NOT_FOUND;
                    end
                    else
                    begin
                        cmd.res_code = ST_UNLOADED;
                        cmd.wr_en    = 1'b1;
                        if (stat.queue_empty || stat.free_below)
                        begin
                            cmd.wr_sel = WR_CLEAR;
                        end
                        else
                        begin
                            cmd.wr_sel = WR_PLACE_MATCH;
                            cmd.pop    = 1'b1;
                        end
                    end
                end
            end
            S_PLACE:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_PLACE_FREE;
                cmd.pop    = 1'b1;
            end
            S_EMIT:
            begin
                cmd.emit = !stat.out_busy;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

/* sv/fpa_datapath.sv */
// Section table, wait queue, configuration, table walk and result register.
module fpa_datapath #(
    parameter int NUM_SECTIONS = 16,
    parameter int QUEUE_DEPTH  = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [fpa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fpa_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            operation,
    input  logic [fpa_pkg::ID_W-1:0]        proc_id,
    input  logic [fpa_pkg::SIZE_W-1:0]      proc_size,
    input  fpa_pkg::ctl_cmd_t               cmd,
    output fpa_pkg::dp_stat_t               stat,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [fpa_pkg::STATUS_W-1:0]    status,
    output logic [fpa_pkg::SEC_IDX_W-1:0]   section_index,
    output logic [fpa_pkg::ID_W-1:0]        placed_id,
    output logic [fpa_pkg::COUNT_W-1:0]     queue_count
);
    import fpa_pkg::*;

    localparam int SW = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
    localparam int NW = $clog2(NUM_SECTIONS + 1);
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int CW = (NW > NSEC_W) ? NW : NSEC_W;
    localparam int XW = (SW > SEC_IDX_W) ? SW : SEC_IDX_W;
    localparam int YW = (FW > COUNT_W) ? FW : COUNT_W;

    logic [NSEC_W-1:0]  num_sections_reg;
    logic [BYTES_W-1:0] section_bytes_reg;

    logic               op_reg;
    logic [ID_W-1:0]    id_reg;
    logic [SIZE_W-1:0]  size_reg;

    logic [ID_W-1:0]         owner_mem [NUM_SECTIONS];
    logic [NUM_SECTIONS-1:0] owner_vld_reg;
    logic [ID_W-1:0]         owner_q_reg;
    logic                    owner_vld_q_reg;

    logic              scan_active_reg;
    logic [NW-1:0]     issue_reg;
    logic              pipe_vld_reg;
    logic [SW-1:0]     pipe_idx_reg;
    logic              done_reg;
    logic              hit_reg;
    logic              free_found_reg;
    logic [SW-1:0]     match_idx_reg;
    logic [SW-1:0]     free_idx_reg;

    logic [ID_W-1:0]   wait_mem [QUEUE_DEPTH];
    logic [QW-1:0]     head_reg;
    logic [QW-1:0]     tail_reg;
    logic [FW-1:0]     fill_reg;
    logic [ID_W-1:0]   head_q_reg;

    status_t           res_status_reg;
    logic [SW-1:0]     res_idx_reg;
    logic [ID_W-1:0]   placed_reg;

    logic                    out_valid_reg;
    logic [STATUS_W-1:0]     out_status_reg;
    logic [SEC_IDX_W-1:0]    out_index_reg;
    logic [ID_W-1:0]         out_placed_reg;
    logic [COUNT_W-1:0]      out_count_reg;

    logic [CW-1:0]     cfg_ext;
    logic [CW-1:0]     n_clamped;
    logic [NW-1:0]     n_eff;
    logic [SW-1:0]     last_idx;
    logic [ID_W-1:0]   key;
    logic [ID_W-1:0]   owner_eff;
    logic              issuing;
    logic              hit_now;
    logic              last_now;
    logic              done_now;
    logic              rd_en;
    logic              free_take;
    logic [SW-1:0]     rd_addr;
    logic [SW-1:0]     wr_addr;
    logic [ID_W-1:0]   wr_data;
    logic [XW-1:0]     index_ext;
    logic [YW-1:0]     count_ext;
    logic [QW-1:0]     head_next;
    logic [QW-1:0]     tail_next;

    always_comb
    begin
        cfg_ext = CW'(num_sections_reg);
        if (cfg_ext == '0)
        begin
            n_clamped = CW'(1);
        end
        else if (cfg_ext > CW'(NUM_SECTIONS))
        begin
            n_clamped = CW'(NUM_SECTIONS);
        end
        else
        begin
            n_clamped = cfg_ext;
        end
        n_eff    = n_clamped[NW-1:0];
        last_idx = SW'(n_eff - NW'(1));
    end

    always_comb
    begin
        key       = (op_reg == OP_UNLOAD) ? id_reg : '0;
        owner_eff = owner_vld_q_reg ? owner_q_reg : '0;
        issuing   = issue_reg < n_eff;
        hit_now   = pipe_vld_reg && (owner_eff == key);
        last_now  = pipe_vld_reg && (pipe_idx_reg == last_idx);
        done_now  = hit_now || last_now;
        rd_en     = scan_active_reg && issuing && !done_now;
        free_take = pipe_vld_reg && !hit_now && (owner_eff == '0) && !free_found_reg;
        rd_addr   = issue_reg[SW-1:0];
    end

    always_comb
    begin
        case (cmd.wr_sel)
            WR_LOAD:
            begin
                wr_addr = match_idx_reg;
                wr_data = id_reg;
            end
            WR_CLEAR:
            begin
                wr_addr = match_idx_reg;
                wr_data = '0;
            end
            WR_PLACE_MATCH:
            begin
                wr_addr = match_idx_reg;
                wr_data = head_q_reg;
            end
            WR_PLACE_FREE:
            begin
                wr_addr = free_idx_reg;
                wr_data = head_q_reg;
            end
            default:
            begin
                wr_addr = match_idx_reg;
                wr_data = '0;
            end
        endcase
    end

    always_comb
    begin
        head_next = (head_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + QW'(1);
        tail_next = (tail_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + QW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_sections_reg  <= NSEC_RESET;
            section_bytes_reg <= BYTES_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_NUM_SECTIONS:  num_sections_reg  <= cfg_data[NSEC_W-1:0];
                CFG_SECTION_BYTES: section_bytes_reg <= cfg_data[BYTES_W-1:0];
                default:           num_sections_reg  <= num_sections_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            op_reg   <= operation;
            id_reg   <= proc_id;
            size_reg <= proc_size;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            owner_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            owner_q_reg     <= owner_mem[rd_addr];
            owner_vld_q_reg <= owner_vld_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owner_vld_reg <= '0;
        end
        else if (cmd.wr_en)
        begin
            owner_vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_active_reg <= 1'b0;
            issue_reg       <= '0;
            pipe_vld_reg    <= 1'b0;
            done_reg        <= 1'b0;
            hit_reg         <= 1'b0;
            free_found_reg  <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            scan_active_reg <= 1'b1;
            issue_reg       <= '0;
            pipe_vld_reg    <= 1'b0;
            done_reg        <= 1'b0;
            hit_reg         <= 1'b0;
            free_found_reg  <= 1'b0;
        end
        else
        begin
            pipe_vld_reg <= rd_en;
            if (rd_en)
            begin
                issue_reg <= issue_reg + NW'(1);
            end
            if (done_now)
            begin
                scan_active_reg <= 1'b0;
                done_reg        <= 1'b1;
            end
            if (hit_now)
            begin
                hit_reg <= 1'b1;
            end
            if (free_take)
            begin
                free_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            pipe_idx_reg <= rd_addr;
        end
        if (hit_now)
        begin
            match_idx_reg <= pipe_idx_reg;
        end
        if (free_take)
        begin
            free_idx_reg <= pipe_idx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            wait_mem[tail_reg] <= id_reg;
        end
        head_q_reg <= wait_mem[head_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (cmd.push)
            begin
                tail_reg <= tail_next;
                fill_reg <= fill_reg + FW'(1);
            end
            else if (cmd.pop)
            begin
                head_reg <= head_next;
                fill_reg <= fill_reg - FW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            placed_reg <= '0;
        end
        else if (cmd.pop)
        begin
            placed_reg <= head_q_reg;
        end
        if (cmd.res_en)
        begin
            res_status_reg <= cmd.res_code;
            if (cmd.res_code == ST_LOADED || cmd.res_code == ST_UNLOADED)
            begin
                res_idx_reg <= match_idx_reg;
            end
            else
            begin
                res_idx_reg <= '0;
            end
        end
    end

    always_comb
    begin
        index_ext = XW'(res_idx_reg);
        count_ext = YW'(fill_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_status_reg <= res_status_reg;
            out_index_reg  <= index_ext[SEC_IDX_W-1:0];
            out_placed_reg <= placed_reg;
            out_count_reg  <= count_ext[COUNT_W-1:0];
        end
    end

    always_comb
    begin
        stat.op          = op_reg;
        stat.too_large   = size_reg > SIZE_W'(section_bytes_reg);
        stat.id_zero     = (id_reg == '0);
        stat.scan_done   = done_reg;
        stat.scan_hit    = hit_reg;
        stat.free_below  = free_found_reg;
        stat.queue_full  = (fill_reg == FW'(QUEUE_DEPTH));
        stat.queue_empty = (fill_reg == '0);
        stat.out_busy    = out_valid_reg && !out_ready;
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign section_index = out_index_reg;
    assign placed_id     = out_placed_reg;
    assign queue_count   = out_count_reg;

endmodule

/* dv/tb.sv */
// Self-checking testbench for the fixed-partition allocator: directed and random requests.
module tb;
    import fpa_pkg::*;

    localparam int N_SEC       = 16;
    localparam int Q_DEPTH     = 16;
    localparam int HOLD_LEN    = 300;
    localparam int SETTLE      = 40;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        status_t              code;
        logic [SEC_IDX_W-1:0] sec;
        logic [ID_W-1:0]      placed;
        logic [COUNT_W-1:0]   waiting;
    } alloc_reply_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic                  operation = OP_LOAD;
    logic [ID_W-1:0]       proc_id   = '0;
    logic [SIZE_W-1:0]     proc_size = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic [SEC_IDX_W-1:0]  section_index;
    logic [ID_W-1:0]       placed_id;
    logic [COUNT_W-1:0]    queue_count;

    // allocator state as the testbench sees it
    logic [ID_W-1:0]    owner_tbl [N_SEC];
    logic [ID_W-1:0]    waitq_ids [Q_DEPTH];
    int                 waitq_head;
    int                 waitq_tail;
    int                 waitq_fill;
    logic [NSEC_W-1:0]  nsec_cfg;
    logic [BYTES_W-1:0] bytes_cfg;
    alloc_reply_t       reply_q [$];

    int fail_count = 0;
    bit valid_up   = 1'b0;
    int burst_left = 0;
    int hold_req   = 0;
    int hold_seen  = 0;
    int hold_left  = 0;
    int stall_mode = 0;
    int mode_left  = 0;

    fixed_partition_allocator_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .proc_id       (proc_id),
        .proc_size     (proc_size),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .section_index (section_index),
        .placed_id     (placed_id),
        .queue_count   (queue_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void flag_error(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
        begin
            $display("%s", msg);
        end
    endfunction

    function automatic int sections_live();
        if (nsec_cfg == 0)
        begin
            return 1;
        end
        if (nsec_cfg > N_SEC)
        begin
            return N_SEC;
        end
        return int'(nsec_cfg);
    endfunction

    function automatic int lowest_holding(logic [ID_W-1:0] id);
        for (int i = 0; i < sections_live(); i++)
        begin
            if (owner_tbl[i] == id)
            begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic alloc_reply_t allocate(logic op, logic [ID_W-1:0] id,
                                              logic [SIZE_W-1:0] size);
        alloc_reply_t r;
        int           slot;
        r.sec    = '0;
        r.placed = '0;
        if (op == OP_LOAD)
        begin
            if (size > bytes_cfg)
            begin
                r.code = ST_TOO_LARGE;
            end
            else
            begin
                slot = lowest_holding('0);
                if (slot >= 0)
                begin
                    owner_tbl[slot] = id;
                    r.sec  = slot[SEC_IDX_W-1:0];
                    r.code = ST_LOADED;
                end
                else if (waitq_fill >= Q_DEPTH)
                begin
                    r.code = ST_QUEUE_FULL;
                end
                else
                begin
                    waitq_ids[waitq_tail] = id;
                    waitq_tail = (waitq_tail + 1) % Q_DEPTH;
                    waitq_fill++;
                    r.code = ST_QUEUED;
                end
            end
        end
        else
        begin
            slot = (id == 0) ? -1 : lowest_holding(id);
            if (slot < 0)
            begin
                r.code = ST_NOT_FOUND;
            end
            else
            begin
                owner_tbl[slot] = '0;
                r.sec  = slot[SEC_IDX_W-1:0];
                r.code = ST_UNLOADED;
                if (waitq_fill > 0)
                begin
                    slot = lowest_holding('0);
                    if (slot >= 0)
                    begin
                        r.placed = waitq_ids[waitq_head];
                        waitq_head = (waitq_head + 1) % Q_DEPTH;
                        waitq_fill--;
                        owner_tbl[slot] = r.placed;
                    end
                end
            end
        end
        r.waiting = waitq_fill[COUNT_W-1:0];
        return r;
    endfunction

    task automatic drop_valid();
        if (valid_up)
        begin
            in_valid <= 1'b0;
            valid_up = 1'b0;
        end
    endtask

    // bursts of random length, random gaps between them
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 15);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0)
        begin
            drop_valid();
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_request(logic op, logic [ID_W-1:0] id, logic [SIZE_W-1:0] size);
        in_valid  <= 1'b1;
        valid_up   = 1'b1;
        operation <= op;
        proc_id   <= id;
        proc_size <= size;
        @(negedge clk);
        while (!in_ready)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        reply_q.push_back(allocate(op, id, size));
        pace_sender();
    endtask

    task automatic wait_drained();
        drop_valid();
        while (reply_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_config(logic [NSEC_W-1:0] n, logic [BYTES_W-1:0] b);
        cfg_write <= 1'b1;
        cfg_index <= CFG_NUM_SECTIONS;
        cfg_data  <= CFG_DATA_W'(n);
        @(posedge clk);
        cfg_index <= CFG_SECTION_BYTES;
        cfg_data  <= b;
        @(posedge clk);
        cfg_write <= 1'b0;
        nsec_cfg  = n;
        bytes_cfg = b;
    endtask

    // mostly loads that fit and unloads of resident ids, some noise
    task automatic send_random(int load_pct);
        logic              op;
        logic [ID_W-1:0]   id;
        logic [SIZE_W-1:0] size;
        int                pick;
        logic [ID_W-1:0]   held [$];
        op   = ($urandom_range(0, 99) < load_pct) ? OP_LOAD : OP_UNLOAD;
        pick = $urandom_range(0, 9);
        size = SIZE_W'($urandom_range(0, 20'hFFFFF));
        if (op == OP_LOAD)
        begin
            id = (pick < 7) ? ID_W'($urandom_range(1, 40)) : ID_W'($urandom_range(0, 9999));
            if ($urandom_range(0, 9) != 0)
            begin
                size = SIZE_W'($urandom_range(0, bytes_cfg));
            end
        end
        else
        begin
            for (int i = 0; i < sections_live(); i++)
            begin
                if (owner_tbl[i] != 0)
                begin
                    held.push_back(owner_tbl[i]);
                end
            end
            if (pick < 8 && held.size() > 0)
            begin
                id = held[$urandom_range(0, held.size() - 1)];
            end
            else if (pick == 8)
            begin
                id = owner_tbl[$urandom_range(0, N_SEC - 1)];
            end
            else
            begin
                id = ID_W'($urandom_range(0, 9999));
            end
        end
        send_request(op, id, size);
    endtask

    task automatic test_basic_requests();
        send_request(OP_LOAD, 9999, 4096);
        send_request(OP_LOAD, 1, 4097);
        send_request(OP_LOAD, 2, 20'hFFFFF);
        send_request(OP_LOAD, 0, 0);
        send_request(OP_LOAD, 9999, 0);
        send_request(OP_UNLOAD, 0, 0);
        send_request(OP_UNLOAD, 1234, 20'hFFFFF);
        send_request(OP_UNLOAD, 9999, 0);
        send_request(OP_UNLOAD, 9999, 0);
    endtask

    // sections beyond the count keep their owners and are not searched
    task automatic test_section_count();
        wait_drained();
        set_config(4, 4096);
        for (int i = 11; i <= 14; i++)
        begin
            send_request(OP_LOAD, i, 1);
        end
        wait_drained();
        set_config(2, 4096);
        send_request(OP_UNLOAD, 13, 0);
        send_request(OP_LOAD, 15, 4096);
        wait_drained();
        set_config(0, 65536);
        send_request(OP_UNLOAD, 12, 0);
        wait_drained();
        set_config(4, 4096);
        send_request(OP_UNLOAD, 13, 0);
    endtask

    // a queued id 0 leaves its section free, so the next head lands below the freed one
    task automatic test_free_below_placement();
        wait_drained();
        set_config(2, 4096);
        send_request(OP_LOAD, 0, 100);
        send_request(OP_LOAD, 21, 200);
        send_request(OP_UNLOAD, 11, 0);
        send_request(OP_UNLOAD, 12, 0);
    endtask

    task automatic test_output_backpressure();
        wait_drained();
        set_config(16, 4096);
        hold_req <= hold_req + 1;
        repeat (30) send_random(55);
        wait_drained();
    endtask

    task automatic test_random_mix();
        int nsec_list  [8] = '{16, 1, 0, 31, 5, 16, 16, 8};
        int bytes_list [8] = '{4096, 65536, 65536, 4096, 13107, 0, 65536, 8192};
        int load_list  [8] = '{55, 80, 50, 60, 60, 60, 50, 45};
        int count_list [8] = '{80, 70, 40, 70, 80, 40, 80, 60};
        for (int p = 0; p < 8; p++)
        begin
            wait_drained();
            set_config(NSEC_W'(nsec_list[p]), BYTES_W'(bytes_list[p]));
            repeat (count_list[p]) send_random(load_list[p]);
        end
    endtask

    // check each result ahead of the edge that accepts it
    always @(negedge clk)
    begin
        alloc_reply_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (reply_q.size() == 0)
            begin
                flag_error($sformatf("unexpected result: status %0d section %0d placed %0d waiting %0d",
                                     status, section_index, placed_id, queue_count));
            end
            else
            begin
                want = reply_q.pop_front();
                if (status !== want.code || section_index !== want.sec ||
                    placed_id !== want.placed || queue_count !== want.waiting)
                begin
                    flag_error($sformatf({"mismatch: expected status %0d section %0d placed %0d",
                                          " waiting %0d, got %0d %0d %0d %0d"},
                                         want.code, want.sec, want.placed, want.waiting,
                                         status, section_index, placed_id, queue_count));
                end
            end
        end
    end

    // pick the next ready value
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_LEN;
        end
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(20, 80);
        end
        else
        begin
            mode_left--;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            case (stall_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= 1'($urandom_range(0, 1));
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    initial
    begin
        for (int i = 0; i < N_SEC; i++)
        begin
            owner_tbl[i] = '0;
        end
        for (int i = 0; i < Q_DEPTH; i++)
        begin
            waitq_ids[i] = '0;
        end
        waitq_head = 0;
        waitq_tail = 0;
        waitq_fill = 0;
        nsec_cfg   = NSEC_RESET;
        bytes_cfg  = BYTES_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_requests();
        test_section_count();
        test_free_below_placement();
        test_output_backpressure();
        test_random_mix();
        wait_drained();
        if (reply_q.size() != 0)
        begin
            flag_error($sformatf("%0d results never arrived", reply_q.size()));
        end
        if (fail_count == 0)
        begin
            $display("tb: done, clean");
        end
        else
        begin
            $display("tb: done, errors");
        end
        $finish;
    end

    initial
    begin
        #5000000;
        $display("tb: done, errors");
        $finish;
    end

endmodule
